FILE: sv/slbp_pkg.sv
// types, codes and constants shared by the status led blink pattern block
package slbp_pkg;

    localparam int unsigned OPCODE_W   = 3;
    localparam int unsigned ERR_CODE_W = 6;
    localparam int unsigned LED_W      = 3;

    // pause after the blinks of an error code, in ticks
    localparam int unsigned PAUSE_TICKS = 12;
    // length of the fast green blip, in ticks
    localparam int unsigned BLIP_TICKS  = 8;
    localparam int unsigned BLIP_LAST   = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK          = 3'd0,
        OP_UNKNOWN       = 3'd1,
        OP_UNKNOWN_PROG  = 3'd2,
        OP_HAPPY         = 3'd3,
        OP_HAPPY_PROG    = 3'd4,
        OP_SAD           = 3'd5
    } t_opcode;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } t_led;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [ERR_CODE_W-1:0] error_code;
    } t_in_item;

    typedef struct packed {
        logic [LED_W-1:0] led_drive;
    } t_out_item;

    // one-hot drive of a single led, or all off
    function automatic logic [LED_W-1:0] f_drive(input t_led led, input logic on);
        logic [LED_W-1:0] v;
        v = '0;
        if (on) begin
            unique case (led)
                SEL_RED:   v = 3'b001;
                SEL_GREEN: v = 3'b010;
                SEL_BLUE:  v = 3'b100;
                default:   v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

FILE: sv/slbp_stream_if.sv
// valid/ready channel carrying one beat of a payload type
interface slbp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/status_led_blink_pattern_core.sv
// an event beat is taken in S_IDLE and updates the mode with no output beat; a tick goes through
// S_DONE to its output register, or through S_MOD, S_EVAL and S_DONE while an error code is shown
// (bit-serial counter modulo); no new beat is taken until a tick is through; events one per
// cycle while idle; the shared subtract/compare unit handles one counter bit per cycle
// reset: synchronous, active low; counter, code and flags clear, red selected,
// no beat pending on the output
module status_led_blink_pattern_core #(
    parameter int unsigned COUNTER_BITS = 32,
    parameter int unsigned CODE_BITS    = 6
) (
    input logic          i_clk,
    input logic          i_rst_n,
    slbp_stream_if.sink   i_in,
    slbp_stream_if.source o_out
);
    import slbp_pkg::*;

    localparam int unsigned DW    = CODE_BITS + 3;
    localparam int unsigned BIT_W = $clog2(COUNTER_BITS);
    localparam int unsigned BLP_W = $clog2(BLIP_TICKS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [COUNTER_BITS-1:0] r_tick, n_tick;
    logic [CODE_BITS-1:0]    r_code, n_code;
    t_led                    r_sel, n_sel;
    logic                    r_blue_pend, n_blue_pend;
    logic                    r_green_pend, n_green_pend;
    logic                    r_blip, n_blip;
    logic [COUNTER_BITS-1:0] r_dvd, n_dvd;
    logic [DW-1:0]           r_rem, n_rem;
    logic [BIT_W-1:0]        r_bit, n_bit;
    logic [LED_W-1:0]        r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    logic [LED_W-1:0]        r_out_led, n_out_led;

    logic                    w_accept;
    logic [COUNTER_BITS-1:0] w_c;
    logic [DW:0]             w_shift;
    logic [DW:0]             w_div;
    logic [DW-1:0]           w_twice;
    t_led                    w_blip_led;

    assign i_in.ready              = (r_state == S_IDLE);
    assign w_accept                = i_in.valid && i_in.ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.payload.led_drive = r_out_led;

    assign w_c     = r_tick + COUNTER_BITS'(1);
    // shared unit: shift in one counter bit, compare with the period, subtract
    assign w_shift = {r_rem, r_dvd[COUNTER_BITS-1]};
    assign w_div   = (DW+1)'({r_code, 1'b0}) + (DW+1)'(PAUSE_TICKS);
    assign w_twice = DW'({r_code, 1'b0});
    assign w_blip_led = w_c[1] ? SEL_GREEN : r_sel;

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_code       = r_code;
        n_sel        = r_sel;
        n_blue_pend  = r_blue_pend;
        n_green_pend = r_green_pend;
        n_blip       = r_blip;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_led    = r_out_led;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_opcode'(i_in.payload.opcode))
                        OP_TICK: begin
                            n_tick = w_c;
                            if (r_code != '0) begin
                                n_dvd   = w_c;
                                n_rem   = '0;
                                n_bit   = BIT_W'(COUNTER_BITS - 1);
                                n_state = S_MOD;
                            end else begin
                                priority if (r_blip ||
                                             (w_c[BLP_W-1:0] == '0 && r_green_pend)) begin
                                    n_res        = f_drive(w_blip_led, w_c[0]);
                                    n_blip       = (w_c[BLP_W-1:0] != BLP_W'(BLIP_LAST));
                                    n_green_pend = 1'b0;
                                end else if (r_sel == SEL_BLUE && r_blue_pend) begin
                                    n_res       = f_drive(r_sel, w_c[0]);
                                    n_blue_pend = 1'b0;
                                end else if (r_sel == SEL_GREEN && r_green_pend) begin
                                    n_res        = f_drive(r_sel, w_c[0]);
                                    n_green_pend = 1'b0;
                                end else begin
                                    n_res = f_drive(r_sel, w_c[2]);
                                end
                                n_state = S_DONE;
                            end
                        end
                        OP_UNKNOWN: begin
                            n_code = '0;
                            n_sel  = SEL_BLUE;
                        end
                        OP_UNKNOWN_PROG: n_blue_pend = 1'b1;
                        OP_HAPPY: begin
                            n_code = '0;
                            n_sel  = SEL_GREEN;
                        end
                        OP_HAPPY_PROG: n_green_pend = 1'b1;
                        OP_SAD: begin
                            n_code = CODE_BITS'(i_in.payload.error_code);
                            n_sel  = SEL_RED;
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                n_rem = (w_shift >= w_div) ? DW'(w_shift - w_div) : DW'(w_shift);
                n_dvd = {r_dvd[COUNTER_BITS-2:0], 1'b0};
                if (r_bit == '0) begin
                    n_state = S_EVAL;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            S_EVAL: begin
                // blinks during the first 2*code ticks, then the pause
                n_res   = (r_rem >= w_twice) ? '0 : f_drive(r_sel, r_rem[0]);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_led   = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tick       <= '0;
            r_code       <= '0;
            r_sel        <= SEL_RED;
            r_blue_pend  <= 1'b0;
            r_green_pend <= 1'b0;
            r_blip       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick       <= n_tick;
            r_code       <= n_code;
            r_sel        <= n_sel;
            r_blue_pend  <= n_blue_pend;
            r_green_pend <= n_green_pend;
            r_blip       <= n_blip;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_bit     <= n_bit;
        r_res     <= n_res;
        r_out_led <= n_out_led;
    end

    a_led_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot0(o_out.payload.led_drive))
        else $error("more than one led driven");

    a_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD || r_state == S_EVAL) |-> ((DW+1)'(r_rem) < w_div))
        else $error("remainder not below blink period");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.payload.opcode == OP_TICK) |=> !i_in.ready)
        else $error("ready while a tick is in work");

    a_code_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_code != '0))
        else $error("modulo running with no error code shown");

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the status led blink pattern core
module testbench;
    import slbp_pkg::*;

    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned CODE_W       = 6;
    localparam int unsigned LIMIT_CYCLES = 1000000;
    localparam int unsigned SETTLE_WAIT  = COUNT_W + 8;
    localparam int unsigned RANDOM_BEATS = 1550;

    // opcodes the block ignores
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        t_in_item    beat;
        int unsigned gap;
        bit          drain;
    } t_pending;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slbp_stream_if #(.t_payload(t_in_item))  in_bus ();
    slbp_stream_if #(.t_payload(t_out_item)) out_bus ();

    status_led_blink_pattern_core #(
        .COUNTER_BITS(COUNT_W),
        .CODE_BITS   (CODE_W)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    always #6 clk = ~clk;

    t_pending         beat_q[$];
    logic [LED_W-1:0] due_led_q[$];
    logic [LED_W-1:0] want_led;
    int unsigned      live_beats;
    int unsigned      fail_count;
    int unsigned      cycle_count;
    logic             owed_none;

    // driver state
    int unsigned gap_left;
    bit          gap_armed;

    // sink state
    int unsigned stall_left;
    int unsigned calm_left;
    bit          sink_calm;

    // shadow of the indicator state
    logic [COUNT_W-1:0] m_ticks;
    logic [CODE_W-1:0]  m_code;
    t_led               m_led;
    logic               m_blue_pend;
    logic               m_green_pend;
    logic               m_blip;

    function automatic logic [LED_W-1:0] lit_led(input t_led led, input logic lit);
        logic [LED_W-1:0] one_hot;
        one_hot = '0;
        if (lit) one_hot[led] = 1'b1;
        return one_hot;
    endfunction

    function automatic void predict_led_drive(input t_in_item it);
        logic [COUNT_W-1:0] c;
        int unsigned        twice;
        int unsigned        phase;
        t_led               led;
        logic [LED_W-1:0]   drv;
        case (it.opcode)
            OP_TICK: begin
                m_ticks = m_ticks + 1'b1;
                c = m_ticks;
                if (m_code != '0) begin
                    twice = 2 * m_code;
                    phase = c % (twice + PAUSE_TICKS);
                    drv = (phase < twice) ? lit_led(m_led, (phase & 1) != 0) : '0;
                end else if (m_blip || (c[2:0] == '0 && m_green_pend)) begin
                    // blip alternates green with the selected led every two ticks
                    led = c[1] ? SEL_GREEN : m_led;
                    drv = lit_led(led, c[0]);
                    m_blip = (c[2:0] != BLIP_LAST);
                    m_green_pend = 1'b0;
                end else if (m_led == SEL_BLUE && m_blue_pend) begin
                    m_blue_pend = 1'b0;
                    drv = lit_led(m_led, c[0]);
                end else if (m_led == SEL_GREEN && m_green_pend) begin
                    m_green_pend = 1'b0;
                    drv = lit_led(m_led, c[0]);
                end else begin
                    drv = lit_led(m_led, c[2]);
                end
                due_led_q.push_back(drv);
            end
            OP_UNKNOWN: begin
                m_code = '0;
                m_led = SEL_BLUE;
            end
            OP_UNKNOWN_PROG: m_blue_pend = 1'b1;
            OP_HAPPY: begin
                m_code = '0;
                m_led = SEL_GREEN;
            end
            OP_HAPPY_PROG: m_green_pend = 1'b1;
            OP_SAD: begin
                m_code = it.error_code[CODE_W-1:0];
                m_led = SEL_RED;
            end
            default: ;
        endcase
    endfunction

    function automatic void add_beat(input logic [OPCODE_W-1:0] op, input int unsigned code,
                                     input bit calm);
        t_pending p;
        p.beat.opcode = op;
        p.beat.error_code = code[ERR_CODE_W-1:0];
        p.gap = calm ? 0 : $urandom_range(0, 19);
        p.drain = 1'b0;
        beat_q.push_back(p);
        if (op != OP_SPARE_LO && op != OP_SPARE_HI) live_beats++;
    endfunction

    // driver: one beat per pending entry but for drain entries, gap drawn per entry
    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
            in_bus.payload <= '0;
            gap_armed = 1'b0;
            gap_left = 0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (beat_q.size() == 0) begin
                in_bus.valid <= 1'b0;
            end else if (beat_q[0].drain) begin
                // hold off until every led beat owed has come back
                if (!in_bus.valid && owed_none) void'(beat_q.pop_front());
                in_bus.valid <= 1'b0;
            end else begin
                if (!gap_armed) begin
                    gap_left = beat_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    in_bus.valid <= 1'b0;
                end else begin
                    in_bus.payload <= beat_q[0].beat;
                    in_bus.valid <= 1'b1;
                    void'(beat_q.pop_front());
                    gap_armed = 1'b0;
                end
            end
        end
    end

    // sink: random stall after each beat, with calm stretches
    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            stall_left = 0;
            calm_left = 0;
            sink_calm = 1'b0;
        end else begin
            if (calm_left == 0) begin
                calm_left = $urandom_range(50, 400);
                sink_calm = ($urandom_range(0, 3) == 0);
            end else begin
                calm_left = calm_left - 1;
            end
            if (out_bus.valid && out_bus.ready)
                stall_left = sink_calm ? 0 : $urandom_range(0, 19);
            else if (stall_left != 0)
                stall_left = stall_left - 1;
            out_bus.ready <= (stall_left == 0);
        end
    end

    // monitor: predict on every accepted input beat, check every led beat
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ticks = '0;
            m_code = '0;
            m_led = SEL_RED;
            m_blue_pend = 1'b0;
            m_green_pend = 1'b0;
            m_blip = 1'b0;
            owed_none <= 1'b1;
        end else begin
            if (in_bus.valid && in_bus.ready) predict_led_drive(in_bus.payload);
            if (out_bus.valid && out_bus.ready) begin
                if (due_led_q.size() == 0) begin
                    $error("led_drive beat with nothing due: expected none, actual %0d",
                           out_bus.payload.led_drive);
                    fail_count++;
                end else begin
                    want_led = due_led_q.pop_front();
                    if (out_bus.payload.led_drive !== want_led) begin
                        $error("led_drive mismatch: expected %0d, actual %0d",
                               want_led, out_bus.payload.led_drive);
                        fail_count++;
                    end
                end
            end
            owed_none <= (due_led_q.size() == 0);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned r;
        int unsigned run_len;
        int unsigned code;
        bit          calm;
        bit          mid_drained;
        logic [OPCODE_W-1:0] op;

        in_bus.valid = 1'b0;
        in_bus.payload = '0;
        out_bus.ready = 1'b0;
        live_beats = 0;
        fail_count = 0;
        cycle_count = 0;
        mid_drained = 1'b0;

        // directed: ignored opcodes, codes on non-sad events, code extremes, progress
        add_beat(OP_SPARE_HI, 63, 1'b0);
        add_beat(OP_SPARE_LO, 0, 1'b0);
        add_beat(OP_TICK, 63, 1'b0);
        add_beat(OP_SAD, 1, 1'b0);
        for (n = 0; n < 3; n++) add_beat(OP_TICK, 0, 1'b1);
        add_beat(OP_SAD, 63, 1'b0);
        add_beat(OP_TICK, 0, 1'b0);
        add_beat(OP_SAD, 0, 1'b0);
        add_beat(OP_TICK, 0, 1'b0);
        add_beat(OP_UNKNOWN, 42, 1'b0);
        add_beat(OP_UNKNOWN_PROG, 21, 1'b0);
        add_beat(OP_TICK, 0, 1'b1);
        add_beat(OP_TICK, 0, 1'b1);
        add_beat(OP_HAPPY, 63, 1'b0);
        add_beat(OP_HAPPY_PROG, 63, 1'b0);
        for (n = 0; n < 3; n++) add_beat(OP_TICK, 0, 1'b0);
        add_beat(OP_SAD, 21, 1'b0);
        add_beat(OP_SAD, 42, 1'b0);
        add_beat(OP_TICK, 0, 1'b0);
        add_beat(OP_HAPPY, 0, 1'b0);
        add_beat(OP_TICK, 0, 1'b0);
        beat_q.push_back('{beat: '0, gap: 0, drain: 1'b1});

        // random: a mode event then a run of mostly ticks with progress and noise
        live_beats = 0;
        while (live_beats < RANDOM_BEATS) begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            if (r < 3) begin
                add_beat(OP_UNKNOWN, $urandom_range(0, 63), calm);
            end else if (r < 6) begin
                add_beat(OP_HAPPY, $urandom_range(0, 63), calm);
            end else begin
                r = $urandom_range(0, 9);
                if (r < 6) code = $urandom_range(1, 5);
                else if (r < 8) code = 0;
                else code = $urandom_range(6, 63);
                add_beat(OP_SAD, code, calm);
            end
            run_len = $urandom_range(4, 40);
            for (n = 0; n < run_len; n++) begin
                r = $urandom_range(0, 19);
                if (r < 13) op = OP_TICK;
                else if (r < 15) op = OP_UNKNOWN_PROG;
                else if (r < 17) op = OP_HAPPY_PROG;
                else op = OPCODE_W'($urandom_range(0, 7));
                add_beat(op, $urandom_range(0, 63), calm);
            end
            if (!mid_drained && live_beats > RANDOM_BEATS / 2) begin
                beat_q.push_back('{beat: '0, gap: 0, drain: 1'b1});
                mid_drained = 1'b1;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_q.size() != 0 || in_bus.valid) @(negedge clk);
        n = 0;
        while (due_led_q.size() != 0 && n < 20000) begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_WAIT) @(negedge clk);
        if (due_led_q.size() != 0) begin
            $error("led_drive beats never returned: expected %0d more, actual 0",
                   due_led_q.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: status_led_blink_pattern_core.f
sv/slbp_pkg.sv
sv/slbp_stream_if.sv
sv/status_led_blink_pattern_core.sv
verif/testbench.sv
